### sv/rld_pkg.sv
// shared types, constants and the log2 table of the robust loss derivative unit
package rld_pkg;

  // log2 table resolution
  localparam int LOG_TABLE_BITS = 8;
  localparam int LOG_N          = 1 << LOG_TABLE_BITS;
  localparam int FREM_W         = 32 - LOG_TABLE_BITS;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  // ln(2) in q0.32
  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
  // (2^35 + 1) / 3, floor(x / 3) = (x * DIV3_M) >> 35 for x below 2^35
  localparam logic [33:0] DIV3_M  = 34'h2_AAAA_AAAB;
  localparam int          DIV3_SH = 35;

  typedef enum logic [1:0] {
    LOSS_HUBER  = 2'd0,
    LOSS_CAUCHY = 2'd1,
    LOSS_TUKEY  = 2'd2
  } loss_kind_e;

  typedef enum logic [1:0] {
    REG_LOSS_KIND            = 2'd0,
    REG_SCALE_DELTA          = 2'd1,
    REG_SCALE_DELTA_SQ       = 2'd2,
    REG_SCALE_DELTA_SQ_RECIP = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  loss_kind;
    logic [23:0] scale_delta;
    logic [31:0] scale_delta_sq;
    logic [31:0] scale_delta_sq_recip;
  } cfg_t;

  typedef struct packed {
    logic signed [39:0] loss_curvature;
    logic [16:0]        loss_slope;
    logic [39:0]        loss_value;
  } res_t;

  typedef logic [16:0] log2_rom_t [LOG_N+1];

  // log2(1 + i/2^B) in q0.16, 24 bits by repeated squaring then rounded
  function automatic log2_rom_t make_log2_rom();
    log2_rom_t   rom;
    logic [63:0] x;
    logic [63:0] r;
    for (int i = 0; i < LOG_N; i++) begin
      x = 64'(LOG_N + i) << (30 - LOG_TABLE_BITS);
      r = '0;
      for (int b = 0; b < 24; b++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= 64'h8000_0000) begin
          x = x >> 1;
          r = r | 64'd1;
        end
      end
      rom[i] = 17'((r + 64'd128) >> 8);
    end
    rom[LOG_N] = ONE_Q16;
    return rom;
  endfunction

  localparam log2_rom_t LOG2_ROM = make_log2_rom();

  // magnitudes stay below 2^34, so the -2^39 floor is never reached
  function automatic logic [39:0] neg_curv(logic [33:0] mag);
    return 40'd0 - {6'd0, mag};
  endfunction

endpackage

### sv/rld_pipe.sv
// pipelined datapath: root, log, two dividers and multipliers of the three losses
module rld_pipe import rld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        in_valid_i,
  input  logic [31:0] squared_error_i,
  input  cfg_t        cfg_i,
  output logic        out_valid_o,
  output res_t        res_o
);

  localparam int ST_SQ0      = 1;
  localparam int SQ_STEPS    = 24;
  localparam int ST_CA_MUL   = 1;
  localparam int ST_CA_A     = 2;
  localparam int ST_NRM0     = 3;
  localparam int NRM_STEPS   = 6;
  localparam int ST_CA_LUT   = ST_NRM0 + NRM_STEPS;
  localparam int ST_CA_INT   = ST_CA_LUT + 1;
  localparam int ST_CA_L2    = ST_CA_INT + 1;
  localparam int ST_CA_LN    = ST_CA_L2 + 1;
  localparam int ST_CA_VAL   = ST_CA_LN + 1;
  localparam int ST_D10      = ST_SQ0 + SQ_STEPS;
  localparam int D1_STEPS    = 17;
  localparam int ST_HU_MUL   = ST_D10;
  localparam int ST_HU_VAL   = ST_D10 + 1;
  localparam int ST_POST     = ST_D10 + D1_STEPS;
  localparam int ST_MUL_A    = ST_POST + 1;
  localparam int ST_MUL_B    = ST_MUL_A + 1;
  localparam int ST_TK_C     = ST_MUL_B + 1;
  localparam int ST_TK_SC    = ST_TK_C + 1;
  localparam int ST_TK_DIV3  = ST_TK_SC + 1;
  localparam int ST_TK_VAL   = ST_TK_DIV3 + 1;
  localparam int ST_D20      = ST_POST + 1;
  localparam int D2_STEPS    = 34;
  localparam int NPIPE       = ST_D20 + D2_STEPS;

  typedef struct packed {
    logic [1:0]        kind;
    logic [31:0]       e;
    logic [31:0]       s;
    logic [31:0]       r;
    logic [23:0]       d;
    logic [47:0]       sq_v;
    logic [47:0]       sq_res;
    logic [63:0]       ca_prod;
    logic [48:0]       ca_a;
    logic [63:0]       ca_x;
    logic [5:0]        ca_k;
    logic [16:0]       ca_lo;
    logic [16:0]       ca_diff;
    logic [FREM_W-1:0] ca_frem;
    logic [16:0]       ca_part;
    logic [21:0]       ca_l2;
    logic [21:0]       ca_ln;
    logic [37:0]       ca_val;
    logic [33:0]       ca_ii;
    logic [33:0]       ca_mag;
    logic [47:0]       hu_prod;
    logic [32:0]       hu_val;
    logic [16:0]       hu_slope;
    logic [47:0]       d1_rem;
    logic [33:0]       d1_div;
    logic [16:0]       d1_quo;
    logic              d1_ovf;
    logic [16:0]       tk_t;
    logic [33:0]       tk_t2;
    logic [50:0]       tk_t3;
    logic [32:0]       tk_c;
    logic [32:0]       tk_sc;
    logic [67:0]       tk_prod3;
    logic [32:0]       tk_val;
    logic [31:0]       d2_rem;
    logic [33:0]       d2_num;
    logic [31:0]       d2_div;
    logic [33:0]       d2_quo;
  } pipe_t;

  pipe_t          st_q [NPIPE];
  pipe_t          st_d [NPIPE];
  logic [NPIPE:0] vld_q;
  res_t           res_q;
  res_t           res_d;

  // entry stage: latch the item with the register values it runs under
  always_comb begin
    st_d[0]        = '0;
    st_d[0].kind   = cfg_i.loss_kind;
    st_d[0].e      = squared_error_i;
    st_d[0].s      = cfg_i.scale_delta_sq;
    st_d[0].r      = cfg_i.scale_delta_sq_recip;
    st_d[0].d      = cfg_i.scale_delta;
    st_d[0].sq_v   = {squared_error_i, 16'd0};
    st_d[0].sq_res = '0;
  end

  for (genvar i = 1; i < NPIPE; i++) begin : g_stage
    localparam int SQ_J = (i >= ST_SQ0 && i < ST_SQ0 + SQ_STEPS) ?
                          ST_SQ0 + SQ_STEPS - 1 - i : 0;
    localparam int NRM_SH = (i >= ST_NRM0 && i < ST_NRM0 + NRM_STEPS) ?
                            (32 >> (i - ST_NRM0)) : 1;
    localparam int D1_J = (i >= ST_D10 && i < ST_D10 + D1_STEPS) ?
                          ST_D10 + D1_STEPS - 1 - i : 0;

    always_comb begin
      pipe_t                    p;
      logic [47:0]              sq_bit;
      logic [48:0]              sq_t;
      logic [31:0]              f32;
      logic [LOG_TABLE_BITS-1:0] idx;
      logic [16:0]              hi;
      logic [17+FREM_W-1:0]     ip;
      logic [53:0]              m54;
      logic [49:0]              d1_cmp;
      logic [32:0]              d2_t;
      logic                     qb;
      logic [65:0]              m66;
      logic [48:0]              c49;
      logic [64:0]              m65;
      logic [33:0]              op3;
      logic [32:0]              twice;
      p      = st_q[i-1];
      sq_bit = '0;
      sq_t   = '0;
      f32    = '0;
      idx    = '0;
      hi     = '0;
      ip     = '0;
      m54    = '0;
      d1_cmp = '0;
      d2_t   = '0;
      qb     = 1'b0;
      m66    = '0;
      c49    = '0;
      m65    = '0;
      op3    = '0;
      twice  = '0;

      // square root of e in q.16, one result bit a stage
      if (i >= ST_SQ0 && i < ST_SQ0 + SQ_STEPS) begin
        sq_bit = 48'd1 << (2 * SQ_J);
        sq_t   = {1'b0, p.sq_res} + {1'b0, sq_bit};
        if ({1'b0, p.sq_v} >= sq_t) begin
          p.sq_v   = p.sq_v - sq_t[47:0];
          p.sq_res = (p.sq_res >> 1) + sq_bit;
        end else begin
          p.sq_res = p.sq_res >> 1;
        end
      end

      // cauchy: aux = r*e + 1, then ln(aux)
      if (i == ST_CA_MUL) begin
        p.ca_prod = 64'(p.r) * 64'(p.e);
      end
      if (i == ST_CA_A) begin
        p.ca_a = {1'b0, p.ca_prod[63:16]} + 49'(ONE_Q16);
      end
      if (i == ST_NRM0) begin
        p.ca_x = 64'(p.ca_a);
        p.ca_k = 6'd63;
      end
      if (i >= ST_NRM0 && i < ST_NRM0 + NRM_STEPS) begin
        if (p.ca_x[63 -: NRM_SH] == '0) begin
          p.ca_x = p.ca_x << NRM_SH;
          p.ca_k = p.ca_k - 6'(NRM_SH);
        end
      end
      if (i == ST_CA_LUT) begin
        f32       = p.ca_x[62:31];
        idx       = f32[31 -: LOG_TABLE_BITS];
        hi        = LOG2_ROM[{1'b0, idx} + 1'b1];
        p.ca_lo   = LOG2_ROM[{1'b0, idx}];
        p.ca_diff = hi - p.ca_lo;
        p.ca_frem = f32[FREM_W-1:0];
      end
      if (i == ST_CA_INT) begin
        ip        = (17+FREM_W)'(p.ca_diff) * (17+FREM_W)'(p.ca_frem);
        p.ca_part = p.ca_lo + ip[17+FREM_W-1:FREM_W];
      end
      if (i == ST_CA_L2) begin
        p.ca_l2 = {p.ca_k - 6'd16, 16'd0} + 22'(p.ca_part);
      end
      if (i == ST_CA_LN) begin
        m54     = 54'(p.ca_l2) * 54'(LN2_Q32);
        p.ca_ln = m54[53:32];
      end
      if (i == ST_CA_VAL) begin
        m54      = 54'(p.s) * 54'(p.ca_ln);
        p.ca_val = m54[53:16];
      end

      // huber outlier value 2*q*d - s, floored at zero
      if (i == ST_HU_MUL) begin
        p.hu_prod = 48'(p.sq_res[23:0]) * 48'(p.d);
      end
      if (i == ST_HU_VAL) begin
        twice    = p.hu_prod[47:15];
        p.hu_val = (twice > 33'(p.s)) ? twice - 33'(p.s) : '0;
      end

      // first divider: huber slope, cauchy 1/aux, tukey e/s
      if (i == ST_D10) begin
        p.d1_quo = '0;
        p.d1_ovf = 1'b0;
        if (p.kind == 2'(LOSS_CAUCHY)) begin
          p.d1_rem = 48'h1_0000_0000;
          p.d1_div = (p.ca_a > 49'h1_0000_0000) ? 34'h2_0000_0000 : p.ca_a[33:0];
        end else if (p.kind == 2'(LOSS_TUKEY)) begin
          p.d1_rem = {p.e, 16'd0};
          p.d1_div = {2'd0, p.s};
        end else begin
          p.d1_rem = {8'd0, p.d, 16'd0};
          p.d1_div = {10'd0, p.sq_res[23:0]};
          p.d1_ovf = {1'b0, p.d} >= {p.sq_res[23:0], 1'b0};
        end
      end
      if (i >= ST_D10 && i < ST_D10 + D1_STEPS) begin
        d1_cmp = 50'(p.d1_div) << D1_J;
        if ({2'd0, p.d1_rem} >= d1_cmp) begin
          p.d1_rem       = p.d1_rem - d1_cmp[47:0];
          p.d1_quo[D1_J] = 1'b1;
        end
      end

      if (i == ST_POST) begin
        if (p.d1_ovf || p.d1_quo > ONE_Q16) begin
          p.hu_slope = ONE_Q16;
        end else if (p.d1_quo == '0) begin
          p.hu_slope = 17'd1;
        end else begin
          p.hu_slope = p.d1_quo;
        end
        p.tk_t = ONE_Q16 - p.d1_quo;
      end

      // cauchy curvature and tukey powers of t
      if (i == ST_MUL_A) begin
        p.ca_ii = 34'(p.d1_quo) * 34'(p.d1_quo);
        p.tk_t2 = 34'(p.tk_t) * 34'(p.tk_t);
      end
      if (i == ST_MUL_B) begin
        m66      = 66'(p.r) * 66'(p.ca_ii);
        p.ca_mag = m66[65:32];
        p.tk_t3  = 51'(p.tk_t2) * 51'(p.tk_t);
      end
      if (i == ST_TK_C) begin
        c49    = 49'h1_0000_0000_0000 - 49'(p.tk_t3);
        p.tk_c = c49[48:16];
      end
      if (i == ST_TK_SC) begin
        m65     = 65'(p.s) * 65'(p.tk_c);
        p.tk_sc = m65[64:32];
      end
      if (i == ST_TK_DIV3) begin
        op3        = (p.s != '0 && p.e <= p.s) ? 34'(p.tk_sc) : 34'(p.s);
        p.tk_prod3 = 68'(op3) * 68'(DIV3_M);
      end
      if (i == ST_TK_VAL) begin
        p.tk_val = p.tk_prod3[DIV3_SH+32:DIV3_SH];
      end

      // second divider: huber and tukey curvature, one dividend bit a stage
      if (i == ST_D20) begin
        p.d2_rem = '0;
        p.d2_quo = '0;
        if (p.kind == 2'(LOSS_TUKEY)) begin
          p.d2_num = {p.tk_t, 17'd0};
          p.d2_div = p.s;
        end else begin
          p.d2_num = {2'd0, p.hu_slope, 15'd0};
          p.d2_div = p.e;
        end
      end
      if (i >= ST_D20 && i < ST_D20 + D2_STEPS) begin
        d2_t = {p.d2_rem, p.d2_num[33]};
        if (d2_t >= {1'b0, p.d2_div}) begin
          d2_t = d2_t - {1'b0, p.d2_div};
          qb   = 1'b1;
        end
        p.d2_rem = d2_t[31:0];
        p.d2_num = p.d2_num << 1;
        p.d2_quo = {p.d2_quo[32:0], qb};
      end

      st_d[i] = p;
    end
  end

  // result select per loss kind
  always_comb begin
    pipe_t q;
    q     = st_q[NPIPE-1];
    res_d = '0;
    unique case (q.kind)
      2'(LOSS_CAUCHY): begin
        res_d.loss_value     = 40'(q.ca_val);
        res_d.loss_slope     = (q.d1_quo == '0) ? 17'd1 : q.d1_quo;
        res_d.loss_curvature = neg_curv(q.ca_mag);
      end
      2'(LOSS_TUKEY): begin
        res_d.loss_value = 40'(q.tk_val);
        if (q.s != '0 && q.e <= q.s) begin
          res_d.loss_slope     = q.tk_t2[32:16];
          res_d.loss_curvature = neg_curv(q.d2_quo);
        end
      end
      default: begin
        if (q.e <= q.s) begin
          res_d.loss_value = 40'(q.e);
          res_d.loss_slope = ONE_Q16;
        end else begin
          res_d.loss_value     = 40'(q.hu_val);
          res_d.loss_slope     = q.hu_slope;
          res_d.loss_curvature = neg_curv(q.d2_quo);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NPIPE-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q  <= st_d;
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q[NPIPE];
  assign res_o       = res_q;

endmodule

### sv/robust_loss_derivative_unit.sv
// top level of the robust loss derivative unit: registers, handshake and output
//
// channel   dir  tdata bits (lowest first)                      notes
// s_axis    in   squared_error[31:0]                             one request per item
// m_axis    out  loss_value[39:0] loss_slope[56:40]              one result per item
//                loss_curvature[96:57] zero[103:97]
// cfg       in   cfg_idx_i selects register, cfg_data_i value    write only, no wait
//
// one item enters per cycle while the output register is empty or being taken; its result
// reaches the output register through the entry stage and each of the pipeline stages
// pipeline depth is set by the 24-step square root, the 17-step divider and the 34-step
// curvature divider that follow each other in the huber path
// reset clears valid bits and loads register defaults; no clearing pass
// the whole pipeline holds while the output register is full and not taken
module robust_loss_derivative_unit import rld_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // squared_error
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // loss_value, loss_slope, loss_curvature, zero pad
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  cfg_t cfg_q;
  cfg_t cfg_d;
  res_t res;
  logic en;

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LOSS_KIND:            cfg_d.loss_kind            = cfg_data_i[1:0];
        REG_SCALE_DELTA:          cfg_d.scale_delta          = cfg_data_i[23:0];
        REG_SCALE_DELTA_SQ:       cfg_d.scale_delta_sq       = cfg_data_i;
        REG_SCALE_DELTA_SQ_RECIP: cfg_d.scale_delta_sq_recip = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loss_kind            <= 2'(LOSS_HUBER);
      cfg_q.scale_delta          <= 24'd65536;
      cfg_q.scale_delta_sq       <= 32'd65536;
      cfg_q.scale_delta_sq_recip <= 32'd65536;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline moves when the output register is empty or being taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  rld_pipe u_pipe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .in_valid_i      (s_axis_tvalid),
    .squared_error_i (s_axis_tdata),
    .cfg_i           (cfg_q),
    .out_valid_o     (m_axis_tvalid),
    .res_o           (res)
  );

  assign m_axis_tdata = {7'd0, res.loss_curvature, res.loss_slope, res.loss_value};

  // slope is a fraction of one in every mode
  a_slope_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.loss_slope <= ONE_Q16)
    else $error("loss slope above one");

  // curvature is never positive
  a_curv_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.loss_curvature[39] || res.loss_curvature == '0))
    else $error("positive loss curvature");

  // value stays within the widest branch, the cauchy log product
  a_val_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.loss_value[39:38] == 2'b00)
    else $error("loss value out of range");

endmodule

### tb/robust_loss_derivative_unit_tb.sv
// self-checking testbench of the robust loss derivative unit: directed and random residuals
module robust_loss_derivative_unit_tb;
  import rld_pkg::*;

  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [1:0]  kind;
    logic [23:0] delta;
    logic [31:0] delta_sq;
    logic [31:0] delta_sq_recip;
  } loss_cfg_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;   // squared_error
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;        // loss_value, loss_slope, loss_curvature, zero pad
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;

  // mirror of the block registers, written together with the block
  loss_cfg_t   loss_cfg;
  // log2(1 + i/2^B) in q0.16
  logic [31:0] log2_tab [LOG_N+1];
  // residuals waiting to be offered, and results owed by the block
  logic [31:0] residual_q [$];
  res_t        loss_expect_q [$];
  int          fail_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  // long receiver hold-off, requested by the sequence, counted by the monitor
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;

  robust_loss_derivative_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // table by repeated squaring of 1+f in q1.30, one log2 bit per step
  function automatic void build_log2_tab();
    logic [63:0] x;
    logic [63:0] r;
    for (int i = 0; i < LOG_N; i++) begin
      x = 64'(LOG_N + i) << (30 - LOG_TABLE_BITS);
      r = '0;
      for (int b = 0; b < 24; b++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= 64'h8000_0000) begin
          x = x >> 1;
          r = r | 64'd1;
        end
      end
      log2_tab[i] = 32'((r + 64'd128) >> 8);
    end
    log2_tab[LOG_N] = 32'd65536;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // natural log of a/65536 in q.16, a at least 65536
  function automatic logic [63:0] ln_q16(logic [63:0] a);
    int          k;
    logic [63:0] frac;
    logic [63:0] f32;
    logic [63:0] idx;
    logic [63:0] rem;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] l2;
    k = 63;
    while (k > 0 && a[k] == 1'b0) k--;
    frac = a - (64'd1 << k);
    f32 = (k <= 32) ? (frac << (32 - k)) : (frac >> (k - 32));
    idx = (f32 >> FREM_W) & 64'(LOG_N - 1);
    rem = f32 & ((64'd1 << FREM_W) - 1);
    lo = 64'(log2_tab[idx]);
    hi = 64'(log2_tab[idx + 1]);
    l2 = (64'(k - 16) << 16) + lo + (((hi - lo) * rem) >> FREM_W);
    return (l2 * 64'(LN2_Q32)) >> 32;
  endfunction

  function automatic res_t loss_predict(logic [31:0] err);
    res_t        res;
    logic [63:0] e;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] d;
    logic [63:0] a;
    logic [63:0] inv;
    logic [63:0] t;
    logic [63:0] c;
    logic [63:0] q;
    logic [63:0] twice;
    logic [63:0] val;
    logic [63:0] slope;
    logic [63:0] mag;
    e = 64'(err);
    s = 64'(loss_cfg.delta_sq);
    r = 64'(loss_cfg.delta_sq_recip);
    d = 64'(loss_cfg.delta);
    if (loss_cfg.kind == LOSS_CAUCHY) begin
      a = ((r * e) >> 16) + 64'd65536;
      inv = (64'd1 << 32) / a;
      val = (s * ln_q16(a)) >> 16;
      slope = (inv != 0) ? inv : 64'd1;
      mag = (r * (inv * inv)) >> 32;
    end else if (loss_cfg.kind == LOSS_TUKEY) begin
      // zero delta squared falls into the clipped branch
      if (s == 0 || e > s) begin
        val = s / 3;
        slope = '0;
        mag = '0;
      end else begin
        t = 64'd65536 - ((e << 16) / s);
        c = ((64'd1 << 48) - t * t * t) >> 16;
        val = ((s * c) >> 32) / 3;
        slope = (t * t) >> 16;
        mag = (t << 17) / s;
      end
    end else begin
      // selector 3 falls back to huber
      if (e <= s) begin
        val = e;
        slope = 64'd65536;
        mag = '0;
      end else begin
        q = int_sqrt(e << 16);
        twice = (64'd2 * q * d) >> 16;
        val = (twice > s) ? twice - s : 64'd0;
        slope = (d << 16) / q;
        if (slope > 64'd65536) slope = 64'd65536;
        if (slope == 0) slope = 64'd1;
        mag = (slope << 15) / e;
      end
    end
    if (val > 64'hFF_FFFF_FFFF) val = 64'hFF_FFFF_FFFF;
    if (mag > 64'h80_0000_0000) mag = 64'h80_0000_0000;
    res.loss_value = val[39:0];
    res.loss_slope = slope[16:0];
    res.loss_curvature = 40'd0 - mag[39:0];
    return res;
  endfunction

  // driver: offers queued residuals, predicts each accepted one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        loss_expect_q.push_back(loss_predict(s_axis_tdata));
      end
      // a request not yet taken stays on the bus unchanged
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (residual_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= residual_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each taken result against the oldest prediction
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[96:0]);
        if (loss_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
          fail_cnt++;
        end else begin
          want = loss_expect_q.pop_front();
          if (got.loss_value !== want.loss_value) begin
            $display("%0t: loss_value expected %h actual %h",
                     $time, want.loss_value, got.loss_value);
            fail_cnt++;
          end
          if (got.loss_slope !== want.loss_slope) begin
            $display("%0t: loss_slope expected %h actual %h",
                     $time, want.loss_slope, got.loss_slope);
            fail_cnt++;
          end
          if (got.loss_curvature !== want.loss_curvature) begin
            $display("%0t: loss_curvature expected %h actual %h",
                     $time, want.loss_curvature, got.loss_curvature);
            fail_cnt++;
          end
        end
        if (m_axis_tdata[103:97] !== 7'd0) begin
          $display("%0t: pad bits expected 0 actual %h", $time, m_axis_tdata[103:97]);
          fail_cnt++;
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      REG_LOSS_KIND:            loss_cfg.kind = value[1:0];
      REG_SCALE_DELTA:          loss_cfg.delta = value[23:0];
      REG_SCALE_DELTA_SQ:       loss_cfg.delta_sq = value;
      REG_SCALE_DELTA_SQ_RECIP: loss_cfg.delta_sq_recip = value;
      default: ;
    endcase
  endtask

  task automatic load_cfg(logic [1:0] kind, logic [23:0] delta, logic [31:0] dsq,
                          logic [31:0] recip);
    write_reg(REG_LOSS_KIND, 32'(kind));
    write_reg(REG_SCALE_DELTA, 32'(delta));
    write_reg(REG_SCALE_DELTA_SQ, dsq);
    write_reg(REG_SCALE_DELTA_SQ_RECIP, recip);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every residual went in and every result came back, then let the pipe settle
  task automatic drain();
    while (residual_q.size() > 0 || s_axis_tvalid || loss_expect_q.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_residual();
    logic [31:0] s;
    s = loss_cfg.delta_sq;
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(s, 0);
      2:       return s + 32'($urandom_range(511)) - 32'd256;
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  task automatic random_cfg();
    logic [23:0] delta;
    logic [63:0] dsq;
    logic [63:0] recip;
    case ($urandom_range(4))
      0:       delta = 24'd1;
      1:       delta = 24'hFF_FFFF;
      2:       delta = 24'd65536;
      3:       delta = 24'($urandom_range(24'hFF_FFFF, 1));
      default: delta = 24'($urandom_range(1 << 20, 1));
    endcase
    dsq = (64'(delta) * 64'(delta)) >> 16;
    // now and then registers that disagree with each other
    if ($urandom_range(5) == 0) dsq = 64'($urandom);
    recip = (dsq == 0) ? 64'hFFFF_FFFF : (64'd1 << 48) / dsq;
    if (recip > 64'hFFFF_FFFF) recip = 64'hFFFF_FFFF;
    if (recip == 0) recip = 64'd1;
    load_cfg(2'($urandom_range(3)), delta, dsq[31:0], recip[31:0]);
  endtask

  initial begin
    logic [31:0] edge_vals [8];
    edge_vals = '{32'd0, 32'd1, 32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001,
                  32'h8000_0000, 32'hFFFF_FFFF, 32'h00C8_0000};
    build_log2_tab();
    loss_cfg = '{kind: LOSS_HUBER, delta: 24'd65536, delta_sq: 32'd65536,
                 delta_sq_recip: 32'd65536};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes under each loss with reset scales
    foreach (edge_vals[i]) residual_q.push_back(edge_vals[i]);
    drain();
    load_cfg(LOSS_CAUCHY, 24'd65536, 32'd65536, 32'd65536);
    foreach (edge_vals[i]) residual_q.push_back(edge_vals[i]);
    drain();
    load_cfg(LOSS_TUKEY, 24'd65536, 32'd65536, 32'd65536);
    foreach (edge_vals[i]) residual_q.push_back(edge_vals[i]);
    drain();
    // tukey with zero delta squared gives all zero
    load_cfg(LOSS_TUKEY, 24'd1, 32'd0, 32'hFFFF_FFFF);
    residual_q.push_back(32'd0);
    residual_q.push_back(32'hFFFF_FFFF);
    drain();
    // unused selector with a huge delta: slope ceiling
    load_cfg(2'd3, 24'hFF_FFFF, 32'd1, 32'hFFFF_FFFF);
    residual_q.push_back(32'd2);
    residual_q.push_back(32'hFFFF_FFFF);
    drain();
    // tiny delta, big delta squared: value clamps to zero, slope floor
    load_cfg(LOSS_HUBER, 24'd1, 32'h0010_0000, 32'd1);
    residual_q.push_back(32'h0010_0001);
    residual_q.push_back(32'hFFFF_FFFF);
    drain();

    // random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 8; ph++) begin
      random_cfg();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      // back pressure: receiver holds off while the sender keeps offering
      if (ph == 4) hold_req = 1'b1;
      for (int i = 0; i < 100; i++) residual_q.push_back(pick_residual());
      drain();
    end

    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
